// ===== src/thse_pkg.sv =====
`timescale 1ns / 1ps
package thse_pkg;

  localparam int ROWS_DEF       = 30;
  localparam int VALUE_BITS_DEF = 16;

  // fixed field widths on the ports
  localparam int ROW_W = 6;
  localparam int COL_W = 6;
  localparam int IN_W  = 16;
  localparam int CNT_W = 16;
  localparam int IDX_W = 13;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_FETCH = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic [ROW_W-1:0] upper_row;
    logic [COL_W-1:0] upper_col;
    logic [ROW_W-1:0] lower_row;
    logic [COL_W-1:0] lower_col;
    logic             finished;
    logic [CNT_W-1:0] total_swaps;
  } res_t;

  // flat index of cell (r,c) in row-major order, c may run one past the row
  function automatic logic [IDX_W-1:0] tri_index(logic [ROW_W-1:0] r,
                                                 logic [COL_W:0] c);
    logic [IDX_W-1:0] rr;
    logic [IDX_W-1:0] prod;
    rr   = IDX_W'(r);
    prod = rr * (rr + IDX_W'(1));
    return (prod >> 1) + IDX_W'(c);
  endfunction

endpackage

// ===== src/thse_if.sv =====
`timescale 1ns / 1ps
interface thse_req_if import thse_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            req_type;
  logic [IN_W-1:0] cell_value;

  modport source (output valid, output req_type, output cell_value, input ready);
  modport sink   (input valid, input req_type, input cell_value, output ready);
endinterface

interface thse_rsp_if import thse_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] upper_row;
  logic [COL_W-1:0] upper_col;
  logic [ROW_W-1:0] lower_row;
  logic [COL_W-1:0] lower_col;
  logic             finished;
  logic [CNT_W-1:0] total_swaps;

  modport source (output valid, output upper_row, output upper_col, output lower_row,
                  output lower_col, output finished, output total_swaps, input ready);
  modport sink   (input valid, input upper_row, input upper_col, input lower_row,
                  input lower_col, input finished, input total_swaps, output ready);
endinterface

// ===== src/triangular_heapify_swap_emitter_unit.sv =====
`timescale 1ns / 1ps
// load request: written to the cell memory while idle; ready stays high for the next request
// fetch request: each sift reads both children and the parent through the single read port
//   (S_RIGHT, S_PARENT, S_CMP); a swap writes back (S_WR) and is emitted, no swap moves on to
//   the next start; after the last, a finished result; ready the cycle after it is handed on
// one request in flight; a new request is taken while a result waits in the output register
// reset clears all control state at once; the cell memory is not cleared
module triangular_heapify_swap_emitter_unit import thse_pkg::*; #(
  parameter int ROWS       = ROWS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  thse_req_if.sink   req,
  thse_rsp_if.source rsp
);

  logic res_req;
  logic res_take;
  logic in_ready;
  res_t res;

  assign res_take  = !rsp.valid || rsp.ready;
  assign req.ready = in_ready;

  thse_seq #(
    .ROWS       (ROWS),
    .VALUE_BITS (VALUE_BITS)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (req.valid),
    .in_ready      (in_ready),
    .in_req_type   (req.req_type),
    .in_cell_value (req.cell_value),
    .res_req       (res_req),
    .res_take      (res_take),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_req && res_take) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_req && res_take) begin
      rsp.upper_row   <= res.upper_row;
      rsp.upper_col   <= res.upper_col;
      rsp.lower_row   <= res.lower_row;
      rsp.lower_col   <= res.lower_col;
      rsp.finished    <= res.finished;
      rsp.total_swaps <= res.total_swaps;
    end
  end

`ifndef SYNTHESIS
  a_done_no_coords: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.finished) |->
      (rsp.upper_row == '0 && rsp.upper_col == '0 &&
       rsp.lower_row == '0 && rsp.lower_col == '0))
    else $error("finished result carries coordinates");

  a_swap_is_parent_child: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.finished) |->
      (rsp.lower_row == rsp.upper_row + ROW_W'(1) &&
       (rsp.lower_col == rsp.upper_col || rsp.lower_col == rsp.upper_col + COL_W'(1))))
    else $error("swap is not between a parent and its child");
`endif

endmodule

// ===== src/thse_cells.sv =====
`timescale 1ns / 1ps
module thse_cells import thse_pkg::*; #(
  parameter int DEPTH = 465,
  parameter int AW    = 9,
  parameter int VW    = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [VW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [VW-1:0] rd_data
);

  logic [VW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/thse_seq.sv =====
`timescale 1ns / 1ps
module thse_seq import thse_pkg::*; #(
  parameter int ROWS       = ROWS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_req_type,
  input  logic [IN_W-1:0] in_cell_value,
  output logic            res_req,
  input  logic            res_take,
  output res_t            res
);

  localparam int CELLS = ROWS * (ROWS + 1) / 2;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int LPW   = $clog2(CELLS + 1);
  localparam int VW    = VALUE_BITS;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_NEXT   = 7'b0000010,
    S_RIGHT  = 7'b0000100,
    S_PARENT = 7'b0001000,
    S_CMP    = 7'b0010000,
    S_WR     = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t           state;
  logic [LPW-1:0]   load_pos;
  logic [ROW_W-1:0] outer_row;
  logic [COL_W-1:0] outer_col;
  logic [ROW_W-1:0] sift_row;
  logic [COL_W-1:0] sift_col;
  logic             sift_active;
  logic             starts_done;
  logic [CNT_W-1:0] swap_counter;
  logic [VW-1:0]    left_val;
  logic [VW-1:0]    child_val;
  logic [VW-1:0]    parent_val;
  logic [COL_W-1:0] child_col;

  logic             accept;
  logic [ROW_W-1:0] child_row;
  logic [COL_W-1:0] sift_col_inc;
  logic [CNT_W-1:0] count_inc;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [VW-1:0]    wr_data;
  logic [AW-1:0]    rd_addr;
  logic [VW-1:0]    rd_data;
  logic [VW-1:0]    cmp_a;
  logic             cmp_lt;

  assign in_ready     = (state == S_IDLE);
  assign accept       = in_valid && in_ready;
  assign res_req      = (state == S_EMIT);
  assign child_row    = sift_row + ROW_W'(1);
  assign sift_col_inc = sift_col + COL_W'(1);
  assign count_inc    = (swap_counter == COUNT_MAX) ? swap_counter
                                                    : swap_counter + CNT_W'(1);

  // one less-than unit: picks the smaller child, then tests it against the parent
  assign cmp_a  = (state == S_CMP) ? child_val : left_val;
  assign cmp_lt = cmp_a < rd_data;

  always_comb begin
    case (state)
      S_NEXT:  rd_addr = AW'(tri_index(child_row, {1'b0, sift_col}));
      S_RIGHT: rd_addr = AW'(tri_index(child_row, {1'b0, sift_col} + 7'd1));
      default: rd_addr = AW'(tri_index(sift_row, {1'b0, sift_col}));
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = load_pos[AW-1:0];
    wr_data = VW'(in_cell_value);
    case (state)
      S_IDLE: begin
        wr_en = accept && (in_req_type == REQ_LOAD) && (load_pos < LPW'(CELLS));
      end
      S_CMP: begin
        wr_en   = cmp_lt;
        wr_addr = AW'(tri_index(sift_row, {1'b0, sift_col}));
        wr_data = child_val;
      end
      S_WR: begin
        wr_en   = 1'b1;
        wr_addr = AW'(tri_index(child_row, {1'b0, child_col}));
        wr_data = parent_val;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  thse_cells #(
    .DEPTH (CELLS),
    .AW    (AW),
    .VW    (VW)
  ) u_cells (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      load_pos     <= '0;
      outer_row    <= ROW_W'(ROWS - 2);
      outer_col    <= '0;
      sift_row     <= '0;
      sift_col     <= '0;
      sift_active  <= 1'b0;
      starts_done  <= 1'b0;
      swap_counter <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_req_type == REQ_LOAD) begin
              if (load_pos < LPW'(CELLS)) begin
                load_pos <= load_pos + LPW'(1);
              end
            end else begin
              state <= S_NEXT;
            end
          end
        end
        S_NEXT: begin
          if (sift_active && (sift_row < ROW_W'(ROWS - 1))) begin
            state <= S_RIGHT;
          end else if (starts_done) begin
            sift_active <= 1'b0;
            state       <= S_EMIT;
          end else begin
            // take the next sift start; another is taken only once this sift has ended
            sift_row    <= outer_row;
            sift_col    <= outer_col;
            sift_active <= 1'b1;
            if (outer_col < outer_row) begin
              outer_col <= outer_col + COL_W'(1);
            end else if (outer_row == '0) begin
              starts_done <= 1'b1;
            end else begin
              outer_row <= outer_row - ROW_W'(1);
              outer_col <= '0;
            end
          end
        end
        S_RIGHT: begin
          left_val <= rd_data;
          state    <= S_PARENT;
        end
        S_PARENT: begin
          child_val <= cmp_lt ? left_val : rd_data;
          child_col <= cmp_lt ? sift_col : sift_col_inc;
          state     <= S_CMP;
        end
        S_CMP: begin
          parent_val <= rd_data;
          if (cmp_lt) begin
            state <= S_WR;
          end else begin
            sift_active <= 1'b0;
            state       <= S_NEXT;
          end
        end
        S_WR: begin
          swap_counter <= count_inc;
          sift_row     <= child_row;
          sift_col     <= child_col;
          state        <= S_EMIT;
        end
        S_EMIT: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result fields, held until the output register takes them
  always_ff @(posedge clk) begin
    if (state == S_WR) begin
      res.upper_row   <= sift_row;
      res.upper_col   <= sift_col;
      res.lower_row   <= child_row;
      res.lower_col   <= child_col;
      res.finished    <= 1'b0;
      res.total_swaps <= count_inc;
    end else if (state == S_NEXT && starts_done &&
                 !(sift_active && (sift_row < ROW_W'(ROWS - 1)))) begin
      res.upper_row   <= '0;
      res.upper_col   <= '0;
      res.lower_row   <= '0;
      res.lower_col   <= '0;
      res.finished    <= 1'b1;
      res.total_swaps <= swap_counter;
    end
  end

`ifndef SYNTHESIS
  a_swap_writes_back: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP && cmp_lt) |=> (state == S_WR))
    else $error("swap did not complete its second write");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (swap_counter >= $past(swap_counter)))
    else $error("swap count went backwards");

  a_sift_in_pyramid: assert property (@(posedge clk) disable iff (rst)
    sift_active |-> (sift_col <= sift_row))
    else $error("sift position outside the pyramid");
`endif

endmodule
